### src/tapt_pkg.sv
// shared types, constants and helper functions of the actuator position tracker
package tapt_pkg;

    // field and datapath widths
    localparam int POS_W      = 18;
    localparam int WIDE_W     = 20;
    localparam int TRAVEL_W   = 13;
    localparam int STARTUP_W  = 10;
    localparam int PCT_W      = 7;
    localparam int ELAPSED_W  = 16;
    localparam int AMOUNT_W   = 8;
    localparam int KIND_W     = 2;
    localparam int POS_PCT_W  = 14;
    localparam int DIV_W      = 20;
    localparam int DIVISOR_W  = 13;
    localparam int DIV_STEPS  = DIV_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    typedef logic signed [POS_W-1:0]  s18_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    // register limits and reset values
    localparam logic [TRAVEL_W-1:0]  TRAVEL_MIN    = 13'd3000;
    localparam logic [TRAVEL_W-1:0]  TRAVEL_MAX    = 13'd8000;
    localparam logic [TRAVEL_W-1:0]  TRAVEL_RESET  = 13'd3500;
    localparam logic [STARTUP_W-1:0] STARTUP_MAX   = 10'd1000;
    localparam logic [STARTUP_W-1:0] STARTUP_RESET = 10'd250;

    // motion constants
    localparam wide_t END_EXTRA = 20'sd2500;
    localparam wide_t S18_MAX   = 20'sd131071;
    localparam wide_t S18_MIN   = -20'sd131072;

    // percent constants
    localparam logic [PCT_W-1:0]     PCT_FULL  = 7'd100;
    localparam logic [PCT_W-1:0]     SNAP_LOW  = 7'd5;
    localparam logic [PCT_W-1:0]     SNAP_HIGH = 7'd98;
    localparam logic [DIVISOR_W-1:0] PCT_SCALE = 13'd100;

    // request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK,
        KIND_TARGET,
        KIND_ADJUST,
        KIND_MANUAL
    } kind_t;

    // configuration register indexes
    typedef enum logic {
        CFG_FULL_TRAVEL,
        CFG_STARTUP
    } cfg_index_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK,
        ST_MAN,
        ST_PCT_LOAD,
        ST_DIV,
        ST_ADJ,
        ST_TGT_LOAD,
        ST_TGT_APPLY,
        ST_DONE
    } state_t;

    // what the running division is for
    typedef enum logic [1:0] {
        DIV_ADJ,
        DIV_TGT,
        DIV_OUT
    } div_op_t;

    // divider request and response
    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    // saturate to the 18-bit signed range
    function automatic s18_t sat18(input wide_t v);
        s18_t r;
        if (v > S18_MAX)
            r = S18_MAX[POS_W-1:0];
        else if (v < S18_MIN)
            r = S18_MIN[POS_W-1:0];
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

    // clamp a signed value to 0..100
    function automatic logic [PCT_W-1:0] clamp_pct(input wide_t v);
        logic [PCT_W-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > wide_t'({1'b0, PCT_FULL}))
            r = PCT_FULL;
        else
            r = v[PCT_W-1:0];
        return r;
    endfunction

    // percent with end snapping, zero for a position at or below zero
    function automatic logic [PCT_W-1:0] snap_pct(input logic [DIV_W-1:0] q,
                                                  input logic pos_positive);
        logic [PCT_W-1:0] r;
        if (!pos_positive || q < DIV_W'(SNAP_LOW))
            r = '0;
        else if (q > DIV_W'(SNAP_HIGH))
            r = PCT_FULL;
        else
            r = q[PCT_W-1:0];
        return r;
    endfunction

endpackage

### src/tapt_cfg_if.sv
// configuration write channel of the actuator position tracker
interface tapt_cfg_if;
    logic                          valid;
    logic                          ready;
    tapt_pkg::cfg_index_t          index;
    logic [tapt_pkg::TRAVEL_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/tapt_cmd_if.sv
// request channel of the actuator position tracker
interface tapt_cmd_if;
    logic                                  valid;
    logic                                  ready;
    logic [tapt_pkg::KIND_W-1:0]           kind;
    logic [tapt_pkg::ELAPSED_W-1:0]        elapsed;
    logic signed [tapt_pkg::AMOUNT_W-1:0]  amount;

    modport source (output valid, kind, elapsed, amount, input ready);
    modport sink   (input valid, kind, elapsed, amount, output ready);
endinterface

### src/tapt_res_if.sv
// result channel of the actuator position tracker
interface tapt_res_if;
    logic                               valid;
    logic                               ready;
    logic                               drive_a;
    logic                               drive_b;
    logic                               enable;
    logic [tapt_pkg::PCT_W-1:0]         position_percent;
    logic signed [tapt_pkg::POS_W-1:0]  outstanding_time;

    modport source (output valid, drive_a, drive_b, enable, position_percent,
                    outstanding_time, input ready);
    modport sink   (input valid, drive_a, drive_b, enable, position_percent,
                    outstanding_time, output ready);
endinterface

### src/tapt_div.sv
// shared restoring divider, one quotient bit per cycle
module tapt_div (
    input  logic               clk,
    input  logic               rst_n,
    input  tapt_pkg::div_req_t req,
    output tapt_pkg::div_rsp_t rsp
);

    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic [tapt_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [tapt_pkg::DIVISOR_W-1:0]     rem_reg, rem_next;
    logic [tapt_pkg::DIV_W-1:0]         quo_reg, quo_next;
    logic [tapt_pkg::DIVISOR_W-1:0]     divisor_reg, divisor_next;

    logic [tapt_pkg::DIVISOR_W:0]       rem_shift;
    logic [tapt_pkg::DIVISOR_W:0]       rem_sub;
    logic                               fits;
    logic                               last_step;

    // one trial subtraction
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[tapt_pkg::DIV_W-1]};
        fits      = rem_shift >= {1'b0, divisor_reg};
        rem_sub   = rem_shift - {1'b0, divisor_reg};
        last_step = cnt_reg == tapt_pkg::DIV_CNT_W'(tapt_pkg::DIV_STEPS - 1);
    end

    // step control and shift
    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        if (req.start)
        begin
            busy_next    = 1'b1;
            cnt_next     = '0;
            rem_next     = '0;
            quo_next     = req.dividend;
            divisor_next = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? rem_sub[tapt_pkg::DIVISOR_W-1:0]
                            : rem_shift[tapt_pkg::DIVISOR_W-1:0];
            quo_next = {quo_reg[tapt_pkg::DIV_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### src/timed_actuator_position_tracker.sv
// top level of the timed actuator position tracker
//
// Open-loop actuator driver that estimates position from run time. Each request
// (tick, set target, adjust percent, manual jog) gives one result with the bridge
// pin levels, the position percent and the signed outstanding move time. One
// shared 20-step restoring divider does all percent and target arithmetic, so a
// request holds the block busy until it returns to idle: one division for a tick
// or manual request, two for a target and three for an adjust, with the result
// loaded on the way back to idle. A new request is taken while the
// previous result still waits in the output register. Configuration writes are
// taken in any cycle and are meant for an idle block; full travel time is clamped
// to 3000..8000 and startup time to at most 1000 on write.
module timed_actuator_position_tracker (
    input  logic clk,
    input  logic rst_n,
    tapt_cfg_if.sink   cfg,
    tapt_cmd_if.sink   cmd,
    tapt_res_if.source res
);

    // sequencer
    tapt_pkg::state_t  state_reg, state_next;
    tapt_pkg::div_op_t op_reg, op_next;

    // actuator state
    tapt_pkg::s18_t                       ext_reg, ext_next;
    tapt_pkg::s18_t                       ret_reg, ret_next;
    tapt_pkg::s18_t                       pos_reg, pos_next;
    logic signed [tapt_pkg::AMOUNT_W-1:0] man_reg, man_next;
    logic                                 pin_a_reg, pin_a_next;
    logic                                 pin_b_reg, pin_b_next;
    logic                                 pin_en_reg, pin_en_next;
    logic [tapt_pkg::TRAVEL_W-1:0]        ftt_reg, ftt_next;
    logic [tapt_pkg::STARTUP_W-1:0]       st_reg, st_next;

    // request payload and working values
    logic [tapt_pkg::ELAPSED_W-1:0]       elapsed_reg, elapsed_next;
    logic signed [tapt_pkg::AMOUNT_W-1:0] amount_reg, amount_next;
    logic [tapt_pkg::PCT_W-1:0]           tgt_pct_reg, tgt_pct_next;
    logic [tapt_pkg::PCT_W-1:0]           pct_reg, pct_next;

    // result register
    logic                                 res_valid_reg, res_valid_next;
    logic                                 res_a_reg, res_b_reg, res_en_reg;
    logic [tapt_pkg::PCT_W-1:0]           res_pct_reg;
    tapt_pkg::s18_t                       res_out_reg;

    // control outputs of the sequencer
    logic                                 cmd_ready;
    logic                                 res_load;
    tapt_pkg::div_req_t                   div_req;
    tapt_pkg::div_rsp_t                   div_rsp;

    // datapath intermediates
    tapt_pkg::wide_t                      pos_w, dt_w, st_w, tgt_w, diff_w, adj_w;
    tapt_pkg::s18_t                       ftt_s;
    tapt_pkg::s18_t                       pos_move, pos_pre, pos_tick, ext_tick, ret_tick;
    tapt_pkg::s18_t                       ext_tgt, ret_tgt, pos_tgt;
    tapt_pkg::s18_t                       outstanding;
    logic                                 tick_idle, tick_extend;
    logic                                 moving, tgt_extend, tgt_retract;

    tapt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tapt_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    case (tapt_pkg::kind_t'(cmd.kind))
                        tapt_pkg::KIND_TICK:   state_next = tapt_pkg::ST_TICK;
                        tapt_pkg::KIND_TARGET: state_next = tapt_pkg::ST_TGT_LOAD;
                        tapt_pkg::KIND_ADJUST: state_next = tapt_pkg::ST_PCT_LOAD;
                        tapt_pkg::KIND_MANUAL: state_next = tapt_pkg::ST_MAN;
                        default:               state_next = tapt_pkg::ST_IDLE;
                    endcase
                end
            end
            tapt_pkg::ST_TICK:      state_next = tapt_pkg::ST_PCT_LOAD;
            tapt_pkg::ST_MAN:       state_next = tapt_pkg::ST_PCT_LOAD;
            tapt_pkg::ST_PCT_LOAD:  state_next = tapt_pkg::ST_DIV;
            tapt_pkg::ST_TGT_LOAD:  state_next = tapt_pkg::ST_DIV;
            tapt_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    case (op_reg)
                        tapt_pkg::DIV_ADJ: state_next = tapt_pkg::ST_ADJ;
                        tapt_pkg::DIV_TGT: state_next = tapt_pkg::ST_TGT_APPLY;
                        tapt_pkg::DIV_OUT: state_next = tapt_pkg::ST_DONE;
                        default:           state_next = tapt_pkg::ST_DONE;
                    endcase
                end
            end
            tapt_pkg::ST_ADJ:       state_next = tapt_pkg::ST_TGT_LOAD;
            tapt_pkg::ST_TGT_APPLY: state_next = tapt_pkg::ST_PCT_LOAD;
            tapt_pkg::ST_DONE:
            begin
                if (!res_valid_reg || res.ready)
                    state_next = tapt_pkg::ST_IDLE;
            end
            default:                state_next = tapt_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        cmd_ready        = state_reg == tapt_pkg::ST_IDLE;
        res_load         = (state_reg == tapt_pkg::ST_DONE) && (!res_valid_reg || res.ready);
        div_req.start    = (state_reg == tapt_pkg::ST_PCT_LOAD) ||
                           (state_reg == tapt_pkg::ST_TGT_LOAD);
        if (state_reg == tapt_pkg::ST_PCT_LOAD)
        begin
            div_req.dividend = (pos_reg > 0)
                ? tapt_pkg::DIV_W'(pos_reg[tapt_pkg::POS_PCT_W-1:0]) *
                  tapt_pkg::DIV_W'(tapt_pkg::PCT_FULL)
                : '0;
            div_req.divisor  = ftt_reg;
        end
        else
        begin
            div_req.dividend = tapt_pkg::DIV_W'(ftt_reg) * tapt_pkg::DIV_W'(tgt_pct_reg);
            div_req.divisor  = tapt_pkg::PCT_SCALE;
        end
    end

    // tick arithmetic
    always_comb
    begin
        pos_w       = tapt_pkg::wide_t'(pos_reg);
        dt_w        = tapt_pkg::wide_t'({1'b0, elapsed_reg});
        ftt_s       = tapt_pkg::s18_t'({{(tapt_pkg::POS_W - tapt_pkg::TRAVEL_W){1'b0}}, ftt_reg});
        tick_idle   = (ext_reg <= 0) && (ret_reg <= 0) && (man_reg == 0);
        tick_extend = (ext_reg > 0) || (man_reg > 0);
        pos_move    = tapt_pkg::sat18(tick_extend ? pos_w + dt_w : pos_w - dt_w);
        pos_pre     = tick_idle ? pos_reg : pos_move;
        if (pos_pre <= 0)
            pos_tick = '0;
        else if (pos_pre >= ftt_s)
            pos_tick = ftt_s;
        else
            pos_tick = pos_pre;
        ext_tick = ext_reg;
        ret_tick = ret_reg;
        if (tick_idle)
        begin
            ext_tick = '0;
            ret_tick = '0;
        end
        else if (man_reg == 0)
        begin
            if (tick_extend)
                ext_tick = tapt_pkg::sat18(tapt_pkg::wide_t'(ext_reg) - dt_w);
            else
                ret_tick = tapt_pkg::sat18(tapt_pkg::wide_t'(ret_reg) - dt_w);
        end
    end

    // target and adjust arithmetic, quotient holds the target time
    always_comb
    begin
        st_w        = tapt_pkg::wide_t'({1'b0, st_reg});
        tgt_w       = tapt_pkg::wide_t'({1'b0, div_rsp.quotient[tapt_pkg::TRAVEL_W-1:0]});
        diff_w      = tgt_w - pos_w;
        moving      = (ext_reg != 0) || (ret_reg != 0);
        tgt_extend  = diff_w > 0;
        tgt_retract = diff_w < 0;
        ext_tgt = tgt_extend
            ? tapt_pkg::sat18(diff_w + ((tgt_pct_reg == tapt_pkg::PCT_FULL)
                                        ? tapt_pkg::END_EXTRA : tapt_pkg::wide_t'(0)))
            : '0;
        ret_tgt = tgt_retract
            ? tapt_pkg::sat18(-diff_w + ((tgt_pct_reg == '0)
                                         ? tapt_pkg::END_EXTRA : tapt_pkg::wide_t'(0)))
            : '0;
        // startup compensation only when starting from rest
        if (!moving && tgt_extend)
            pos_tgt = tapt_pkg::sat18(pos_w - st_w);
        else if (!moving && tgt_retract)
            pos_tgt = tapt_pkg::sat18(pos_w + st_w);
        else
            pos_tgt = pos_reg;
        adj_w = tapt_pkg::wide_t'({1'b0, pct_reg}) + tapt_pkg::wide_t'(amount_reg);
    end

    // signed outstanding time
    always_comb
    begin
        if (ext_reg > 0)
            outstanding = ext_reg;
        else if (ret_reg > 0)
            outstanding = -ret_reg;
        else
            outstanding = '0;
    end

    // datapath next values
    always_comb
    begin
        op_next      = op_reg;
        ext_next     = ext_reg;
        ret_next     = ret_reg;
        pos_next     = pos_reg;
        man_next     = man_reg;
        pin_a_next   = pin_a_reg;
        pin_b_next   = pin_b_reg;
        pin_en_next  = pin_en_reg;
        ftt_next     = ftt_reg;
        st_next      = st_reg;
        elapsed_next = elapsed_reg;
        amount_next  = amount_reg;
        tgt_pct_next = tgt_pct_reg;
        pct_next     = pct_reg;

        // configuration writes
        if (cfg.valid)
        begin
            case (cfg.index)
                tapt_pkg::CFG_FULL_TRAVEL:
                begin
                    if (cfg.data < tapt_pkg::TRAVEL_MIN)
                        ftt_next = tapt_pkg::TRAVEL_MIN;
                    else if (cfg.data > tapt_pkg::TRAVEL_MAX)
                        ftt_next = tapt_pkg::TRAVEL_MAX;
                    else
                        ftt_next = cfg.data;
                end
                tapt_pkg::CFG_STARTUP:
                begin
                    if (cfg.data[tapt_pkg::STARTUP_W-1:0] > tapt_pkg::STARTUP_MAX)
                        st_next = tapt_pkg::STARTUP_MAX;
                    else
                        st_next = cfg.data[tapt_pkg::STARTUP_W-1:0];
                end
                default:
                begin
                    ftt_next = ftt_reg;
                end
            endcase
        end

        case (state_reg)
            tapt_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    elapsed_next = cmd.elapsed;
                    amount_next  = cmd.amount;
                    tgt_pct_next = tapt_pkg::clamp_pct(tapt_pkg::wide_t'(cmd.amount));
                    op_next      = (tapt_pkg::kind_t'(cmd.kind) == tapt_pkg::KIND_ADJUST)
                                   ? tapt_pkg::DIV_ADJ : tapt_pkg::DIV_OUT;
                end
            end
            tapt_pkg::ST_TICK:
            begin
                pin_a_next  = !tick_idle && !tick_extend;
                pin_b_next  = !tick_idle && tick_extend;
                pin_en_next = 1'b1;
                ext_next    = ext_tick;
                ret_next    = ret_tick;
                pos_next    = pos_tick;
            end
            tapt_pkg::ST_MAN:
            begin
                man_next = amount_reg;
            end
            tapt_pkg::ST_DIV:
            begin
                if (div_rsp.done && op_reg != tapt_pkg::DIV_TGT)
                    pct_next = tapt_pkg::snap_pct(div_rsp.quotient, pos_reg > 0);
            end
            tapt_pkg::ST_ADJ:
            begin
                tgt_pct_next = tapt_pkg::clamp_pct(adj_w);
            end
            tapt_pkg::ST_TGT_LOAD:
            begin
                op_next = tapt_pkg::DIV_TGT;
            end
            tapt_pkg::ST_TGT_APPLY:
            begin
                op_next  = tapt_pkg::DIV_OUT;
                man_next = '0;
                ext_next = ext_tgt;
                ret_next = ret_tgt;
                pos_next = pos_tgt;
            end
            default:
            begin
                op_next = op_reg;
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        if (res_load)
            res_valid_next = 1'b1;
        else if (res.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    // control and actuator state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tapt_pkg::ST_IDLE;
            op_reg        <= tapt_pkg::DIV_OUT;
            res_valid_reg <= 1'b0;
            ext_reg       <= '0;
            ret_reg       <= '0;
            pos_reg       <= '0;
            man_reg       <= '0;
            pin_a_reg     <= 1'b0;
            pin_b_reg     <= 1'b0;
            pin_en_reg    <= 1'b0;
            ftt_reg       <= tapt_pkg::TRAVEL_RESET;
            st_reg        <= tapt_pkg::STARTUP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            res_valid_reg <= res_valid_next;
            ext_reg       <= ext_next;
            ret_reg       <= ret_next;
            pos_reg       <= pos_next;
            man_reg       <= man_next;
            pin_a_reg     <= pin_a_next;
            pin_b_reg     <= pin_b_next;
            pin_en_reg    <= pin_en_next;
            ftt_reg       <= ftt_next;
            st_reg        <= st_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        elapsed_reg <= elapsed_next;
        amount_reg  <= amount_next;
        tgt_pct_reg <= tgt_pct_next;
        pct_reg     <= pct_next;
        if (res_load)
        begin
            res_a_reg   <= pin_a_reg;
            res_b_reg   <= pin_b_reg;
            res_en_reg  <= pin_en_reg;
            res_pct_reg <= pct_reg;
            res_out_reg <= outstanding;
        end
    end

    // port drive
    assign cfg.ready            = 1'b1;
    assign cmd.ready            = cmd_ready;
    assign res.valid            = res_valid_reg;
    assign res.drive_a          = res_a_reg;
    assign res.drive_b          = res_b_reg;
    assign res.enable           = res_en_reg;
    assign res.position_percent = res_pct_reg;
    assign res.outstanding_time = res_out_reg;

    // extend and retract time are never outstanding together
    assert property (@(posedge clk) disable iff (!rst_n)
        !((ext_reg > 0) && (ret_reg > 0)))
        else $error("extend and retract both outstanding");

    // an accepted request makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> !cmd.ready)
        else $error("request accepted while still busy");

    // pins move only on a tick
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != tapt_pkg::ST_TICK) |=> $stable({pin_a_reg, pin_b_reg, pin_en_reg}))
        else $error("pin levels changed outside a tick");

    // divider completes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == tapt_pkg::ST_DIV))
        else $error("divider done outside the wait state");

endmodule
